FILE: rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// shared widths, register indexes and types of the 3x3 median filter
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIX_W      = 16;
    localparam int ROW_W      = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_DATA_W = 48;
    localparam int WIN_N      = 9;
    localparam int RANK_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    typedef logic [WIN_N-1:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             lastc;
        logic             lastr;
    } t_pos;

endpackage

FILE: rtl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mf3_pos.sv
// ----------------------------------------------------------------------------
// mf3_pos
// raster position of the next input pixel and its last column / last row flags
// ----------------------------------------------------------------------------
module mf3_pos (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic [mf3_pkg::WIDTH_W-1:0]    i_width,
    input  logic [mf3_pkg::HEIGHT_W-1:0]   i_height,
    output mf3_pkg::t_pos                  o_pos
);
    import mf3_pkg::*;

    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                lastc;
    logic                lastr;

    always_comb begin
        if (i_width < WIDTH_W'(2)) begin
            w_eff = WIDTH_W'(2);
        end else if (i_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = i_width;
        end
        h_eff = (i_height < HEIGHT_W'(2)) ? HEIGHT_W'(2) : i_height;
        lastc = WIDTH_W'(r_col) >= (w_eff - WIDTH_W'(1));
        lastr = r_row >= (h_eff - HEIGHT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_advance) begin
            if (lastc) begin
                r_col <= '0;
                r_row <= lastr ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    assign o_pos = '{row: r_row, col: r_col, lastc: lastc, lastr: lastr};

endmodule

FILE: rtl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// median of a masked part of the 3x3 window by rank selection
// ----------------------------------------------------------------------------
module mf3_median (
    input  mf3_pkg::t_window           i_win,
    input  logic                       i_rlo,
    input  logic                       i_clo,
    output logic [mf3_pkg::PIX_W-1:0]  o_median
);
    import mf3_pkg::*;

    logic [WIN_N-1:0]              mask;
    logic [WIN_N-1:0][RANK_W-1:0]  rank;
    logic [RANK_W-1:0]             k_lo;
    logic [RANK_W-1:0]             k_hi;
    logic [PIX_W-1:0]              v_lo;
    logic [PIX_W-1:0]              v_hi;
    logic [PIX_W:0]                sum;

    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            mask[i] = ((i / 3) >= 1 || !i_rlo) && ((i % 3) >= 1 || !i_clo);
        end
        case ({i_rlo, i_clo})
            2'b00:   begin k_lo = RANK_W'(4); k_hi = RANK_W'(4); end
            2'b11:   begin k_lo = RANK_W'(1); k_hi = RANK_W'(2); end
            default: begin k_lo = RANK_W'(2); k_hi = RANK_W'(3); end
        endcase
        for (int i = 0; i < WIN_N; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WIN_N; j++) begin
                if (j != i && mask[j] && (i_win[j] < i_win[i] ||
                        (i_win[j] == i_win[i] && j < i))) begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
        end
        v_lo = '0;
        v_hi = '0;
        for (int i = 0; i < WIN_N; i++) begin
            if (mask[i] && rank[i] == k_lo) begin
                v_lo = v_lo | i_win[i];
            end
            if (mask[i] && rank[i] == k_hi) begin
                v_hi = v_hi | i_win[i];
            end
        end
        sum      = {1'b0, v_lo} + {1'b0, v_hi};
        o_median = sum[PIX_W:1];
    end

endmodule

FILE: rtl/median_filter_3x3_shrinking_border.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_shrinking_border
// streaming 3x3 median filter, border pixels use the in-image neighbours only
//
// channel   dir  handshake               content
// s_axis    in   tvalid/tready           tdata: pixel_value
// m_axis    out  tvalid/tready           tdata: out_row, out_col, median_value
//                                        tlast: last_of_run, tuser: frame_done
// cfg       in   i_cfg_we                index 0 image_width, 1 image_height
//
// one pixel per cycle while each pixel gives at most one result and m_axis is not stalled
// a pixel with n results holds the window stage until all n are issued (n on last row: 2,
// row end: up to 4); one shared median unit drives the output register
// a pixel beat passes the s1 register, the window stage and the output register
// synchronous reset clears control and the window, line buffers are not cleared
// output stalls back up through the window stage into s_axis_tready
// ----------------------------------------------------------------------------
module median_filter_3x3_shrinking_border (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mf3_pkg::PIX_W-1:0]         s_axis_tdata,   // pixel_value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mf3_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // out_row, out_col, median_value
    output logic                              m_axis_tlast,   // last_of_run
    output logic                              m_axis_tuser,   // frame_done
    input  logic                              i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mf3_pkg::CFG_W-1:0]         i_cfg_data
);
    import mf3_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    t_pos                pos;
    logic                accept;

    logic                r_s1_valid;
    logic [PIX_W-1:0]    r_s1_px;
    t_pos                r_s1_pos;
    logic [PIX_W-1:0]    q_older;
    logic [PIX_W-1:0]    q_newer;
    logic                s1_move;

    t_window             r_win;
    logic [3:0]          r_pend;
    logic [ROW_W-1:0]    r_s2_row;
    logic [COL_W-1:0]    r_s2_col;
    logic                r_s2_rtop;
    logic                r_s2_cl;

    logic                out_ld;
    logic                issue;
    logic [1:0]          sel;
    logic [3:0]          pend_after;
    logic                rlo;
    logic                clo;
    logic [PIX_W-1:0]    median;

    logic                r_out_valid;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;
    logic [PIX_W-1:0]    r_out_med;
    logic                r_out_last;
    logic                r_out_done;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
            endcase
        end
    end

    mf3_pos u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_pos     (pos)
    );

    mf3_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_older (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_pos.col),
        .i_wdata (q_newer),
        .i_re    (accept),
        .i_raddr (pos.col),
        .o_rdata (q_older)
    );

    mf3_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_newer (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_pos.col),
        .i_wdata (r_s1_px),
        .i_re    (accept),
        .i_raddr (pos.col),
        .o_rdata (q_newer)
    );

    // result selection
    always_comb begin
        out_ld = !r_out_valid || m_axis_tready;
        issue  = (r_pend != 4'd0) && out_ld;
        if (r_pend[0]) begin
            sel = 2'd0;
        end else if (r_pend[1]) begin
            sel = 2'd1;
        end else if (r_pend[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        pend_after = issue ? (r_pend & ~(4'd1 << sel)) : r_pend;
        rlo        = sel[1] ? 1'b1 : r_s2_rtop;
        clo        = sel[0] ? 1'b1 : r_s2_cl;
        s1_move    = r_s1_valid && (pend_after == 4'd0);
        s_axis_tready = !r_s1_valid || s1_move;
        accept     = s_axis_tvalid && s_axis_tready;
    end

    mf3_median u_median (
        .i_win    (r_win),
        .i_rlo    (rlo),
        .i_clo    (clo),
        .o_median (median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_pend      <= '0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= q_older;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= q_newer;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_s1_px;
                r_pend   <= {r_s1_pos.lastr & r_s1_pos.lastc,
                             r_s1_pos.lastr & (r_s1_pos.col != '0),
                             (r_s1_pos.row != '0) & r_s1_pos.lastc,
                             (r_s1_pos.row != '0) & (r_s1_pos.col != '0)};
            end else begin
                r_pend <= pend_after;
            end

            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px  <= s_axis_tdata;
            r_s1_pos <= pos;
        end
        if (s1_move) begin
            r_s2_row  <= r_s1_pos.row;
            r_s2_col  <= r_s1_pos.col;
            r_s2_rtop <= r_s1_pos.row < ROW_W'(2);
            r_s2_cl   <= r_s1_pos.col < COL_W'(2);
        end
        if (issue) begin
            r_out_row  <= sel[1] ? r_s2_row : r_s2_row - ROW_W'(1);
            r_out_col  <= sel[0] ? r_s2_col : r_s2_col - COL_W'(1);
            r_out_med  <= median;
            r_out_last <= pend_after == 4'd0;
            r_out_done <= sel == 2'd3;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - ROW_W - COL_W - PIX_W)'(0),
                            r_out_med, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_done;

endmodule

FILE: rtl/mf3_checker.sv
// ----------------------------------------------------------------------------
// mf3_checker
// port level checks of the median filter, bound to the top level
// ----------------------------------------------------------------------------
module mf3_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [mf3_pkg::PIX_W-1:0]         s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mf3_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic                              m_axis_tlast,
    input logic                              m_axis_tuser,
    input logic                              i_cfg_we,
    input logic [mf3_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input logic [mf3_pkg::CFG_W-1:0]         i_cfg_data
);
    import mf3_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat right after reset");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end beat not marked last");

    a_done_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[ROW_W-1:0] != '0 && m_axis_tdata[ROW_W+COL_W-1:ROW_W] != '0)
        else $error("frame end beat not at a bottom right corner");

endmodule

bind median_filter_3x3_shrinking_border mf3_checker u_mf3_checker (.*);
